@@ hdl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define MU_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// concurrent check that also runs during reset
`define MU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ hdl/mu_pkg.sv @@
// shared constants and control/status types for the multiset unranker
// no dependencies
`timescale 1ns / 1ps

package mu_pkg;

    localparam int RANK_W  = 64;
    localparam int LEN_W   = 5;
    localparam int DIG_W   = 8;
    localparam int DIV_CYC = RANK_W / DIG_W;

    // register indexes of the configuration port
    localparam logic REG_SEQ_LEN     = 1'b0;
    localparam logic REG_VALUE_COUNT = 1'b1;

    typedef struct packed {
        logic load;
        logic tot_start;
        logic set_oor;
        logic pos_init;
        logic cnt_start;
        logic take;
        logic sub;
        logic val_zero;
        logic val_base;
        logic emit;
        logic next_pos;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic binom_done;
        logic hit;
        logic off_lt_left;
        logic last_pos;
        logic out_free;
        logic oor;
    } t_sts;

endpackage

@@ hdl/mu_rank_if.sv @@
// request channel carrying one rank
// depends on mu_pkg
`timescale 1ns / 1ps

interface mu_rank_if;
    logic                        valid;
    logic                        ready;
    logic [mu_pkg::RANK_W-1:0]   rank;

    modport source (output valid, output rank, input ready);
    modport sink   (input valid, input rank, output ready);
endinterface

@@ hdl/mu_res_if.sv @@
// result channel carrying one sequence element
// no dependencies
`timescale 1ns / 1ps

interface mu_res_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  out_of_range;

    modport source (output valid, output value, output last, output out_of_range, input ready);
    modport sink   (input valid, input value, input last, input out_of_range, output ready);
endinterface

@@ hdl/multiset_unrank.sv @@
// top level of the multiset combination unranker: config registers, controller, datapath
// depends on mu_pkg, mu_rank_if, mu_res_if, mu_ctrl, mu_datapath
//
// channel      dir  handshake      payload
// i_rank_ch    in   valid/ready    rank (64)
// o_res_ch     out  valid/ready    value, last, out_of_range
// apb          in   psel/penable   paddr, pwdata -> prdata
//
// a rank is accepted and dropped when seq_len is 0, otherwise a binomial for the total,
//   then per position one binomial per try (none when out of range), where a binomial
//   takes t = min(k, n-k) multiply/divide rounds in the shared binomial unit
//   (split multiply, low half then high half, then exact divide)
// synchronous active-low reset, no clearing pass; the result register holds while
// o_res_ch.ready is low and the controller waits in its emit state
`timescale 1ns / 1ps

module multiset_unrank #(
    parameter int MAX_LEN    = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mu_rank_if.sink     i_rank_ch,
    mu_res_if.source    o_res_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW   = mu_pkg::LEN_W;
    // room for seq_len plus value_count in binomial arguments
    localparam int NW   = VALUE_BITS + 6;
    localparam int MAXC = (MAX_LEN > 31) ? 31 : MAX_LEN;

    logic [LW-1:0]         r_seq_len;
    logic [VALUE_BITS-1:0] r_value_count;
    logic [LW-1:0]         w_n;
    logic                  w_wr;
    mu_pkg::t_cmd          w_cmd;
    mu_pkg::t_sts          w_sts;

    // apb write in the access phase, no wait states
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len     <= LW'(1);
            r_value_count <= VALUE_BITS'(1);
        end else if (w_wr) begin
            case (paddr[2])
                mu_pkg::REG_SEQ_LEN:     r_seq_len     <= pwdata[LW-1:0];
                mu_pkg::REG_VALUE_COUNT: r_value_count <= pwdata[VALUE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mu_pkg::REG_SEQ_LEN:     prdata = 32'(r_seq_len);
            mu_pkg::REG_VALUE_COUNT: prdata = 32'(r_value_count);
            default:                 prdata = '0;
        endcase
    end

    // lengths beyond the build limit are clamped
    assign w_n = (r_seq_len > LW'(MAXC)) ? LW'(MAXC) : r_seq_len;

    mu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rank_ch.valid),
        .o_in_ready (i_rank_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mu_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .NW         (NW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_n         (w_n),
        .i_m         (r_value_count),
        .i_rank      (i_rank_ch.rank),
        .i_out_ready (o_res_ch.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_res_ch.valid),
        .o_value     (o_res_ch.value),
        .o_last      (o_res_ch.last),
        .o_oor       (o_res_ch.out_of_range)
    );

endmodule

@@ hdl/mu_binom.sv @@
// binomial coefficient unit with an overflow flag: split multiply, then exact divide 8 bits a cycle
// depends on mu_pkg
`timescale 1ns / 1ps

module mu_binom #(
    parameter int NW = 22
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NW-1:0]               i_n,
    input  logic [mu_pkg::LEN_W-1:0]    i_t,
    output logic                        o_done,
    output logic [mu_pkg::RANK_W-1:0]   o_count,
    output logic                        o_big
);

    localparam int RW = mu_pkg::RANK_W;
    localparam int LW = mu_pkg::LEN_W;
    localparam int DW = mu_pkg::DIG_W;
    localparam int PW = RW + NW;
    localparam int IW = LW + 1;
    localparam int HW = RW / 2;
    localparam int MW = HW + NW;
    localparam int CW = $clog2(mu_pkg::DIV_CYC);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_CHK  = 3'd1;
    localparam logic [2:0] B_MHI  = 3'd2;
    localparam logic [2:0] B_OVF  = 3'd3;
    localparam logic [2:0] B_DIV  = 3'd4;

    logic [2:0]    r_state;
    logic [NW-1:0] r_n;
    logic [LW-1:0] r_tt;
    logic [IW-1:0] r_i;
    logic [RW-1:0] r_c;
    logic [PW-1:0] r_p;
    logic [LW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_big;
    logic          r_done;

    logic          w_t_gt;
    logic [NW-1:0] w_nt;
    logic [LW-1:0] w_tsel;
    logic [NW-1:0] w_x;
    logic [HW-1:0] w_mop;
    logic [MW-1:0] w_pp;
    logic [NW-1:0] w_hi;
    logic [LW-1:0] w_rem;
    logic [DW-1:0] w_q;
    logic [LW:0]   w_d;

    assign w_t_gt = NW'(i_t) > i_n;
    assign w_nt   = i_n - NW'(i_t);
    // use the smaller of t and n-t
    assign w_tsel = (NW'(i_t) > w_nt) ? w_nt[LW-1:0] : i_t;
    assign w_x    = r_n - NW'(r_tt) + NW'(r_i);
    // low half of the running count first, high half the cycle after
    assign w_mop  = (r_state == B_CHK) ? r_c[HW-1:0] : r_c[RW-1:HW];
    assign w_pp   = MW'(w_mop) * MW'(w_x);
    assign w_hi   = r_p[PW-1:RW];

    // one quotient byte, msb first
    always_comb begin
        w_rem = r_rem;
        w_q   = '0;
        w_d   = '0;
        for (int k = 0; k < DW; k++) begin
            w_d = {w_rem, r_p[RW-1-k]};
            if (w_d >= r_i) begin
                w_d          = w_d - r_i;
                w_q[DW-1-k]  = 1'b1;
            end
            w_rem = w_d[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_n;
                        r_c     <= w_t_gt ? '0 : RW'(1);
                        r_tt    <= w_t_gt ? '0 : w_tsel;
                        r_i     <= IW'(1);
                        r_big   <= 1'b0;
                        r_state <= B_CHK;
                    end
                end
                B_CHK: begin
                    if (r_i > IW'(r_tt)) begin
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end else begin
                        r_p     <= PW'(w_pp);
                        r_state <= B_MHI;
                    end
                end
                B_MHI: begin
                    r_p     <= r_p + (PW'(w_pp) << HW);
                    r_state <= B_OVF;
                end
                B_OVF: begin
                    // quotient of 2^64 or more
                    if (w_hi >= NW'(r_i)) begin
                        r_big   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= B_IDLE;
                    end else begin
                        r_rem   <= w_hi[LW-1:0];
                        r_cnt   <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem <= w_rem;
                    r_c   <= {r_c[RW-DW-1:0], w_q};
                    r_p   <= r_p << DW;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(mu_pkg::DIV_CYC - 1)) begin
                        r_i     <= r_i + IW'(1);
                        r_state <= B_CHK;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_count = r_c;
    assign o_big   = r_big;

endmodule

@@ hdl/mu_datapath.sv @@
// datapath: rank, base, offset and position registers, binomial unit, result register
// depends on mu_pkg, mu_binom
`timescale 1ns / 1ps

module mu_datapath #(
    parameter int VALUE_BITS = 16,
    parameter int NW         = 22
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mu_pkg::t_cmd                i_cmd,
    input  logic [mu_pkg::LEN_W-1:0]    i_n,
    input  logic [VALUE_BITS-1:0]       i_m,
    input  logic [mu_pkg::RANK_W-1:0]   i_rank,
    input  logic                        i_out_ready,
    output mu_pkg::t_sts                o_sts,
    output logic                        o_out_valid,
    output logic [VALUE_BITS-1:0]       o_value,
    output logic                        o_last,
    output logic                        o_oor
);

    localparam int RW = mu_pkg::RANK_W;
    localparam int LW = mu_pkg::LEN_W;
    localparam int VB = VALUE_BITS;

    logic [RW-1:0] r_rank;
    logic [VB-1:0] r_base;
    logic [VB-1:0] r_left;
    logic [VB-1:0] r_off;
    logic [LW-1:0] r_pos;
    logic          r_oor;
    logic [VB-1:0] r_val;
    logic          r_ov;
    logic [VB-1:0] r_out_value;
    logic          r_out_last;
    logic          r_out_oor;

    logic [LW-1:0] w_rest;
    logic [VB-1:0] w_avail;
    logic [NW-1:0] w_bn;
    logic [LW-1:0] w_bt;
    logic          w_done;
    logic [RW-1:0] w_count;
    logic          w_big;
    logic          w_last_pos;

    assign w_rest  = i_n - r_pos - LW'(1);
    assign w_avail = r_left - r_off;
    assign w_bn    = i_cmd.tot_start ? (NW'(i_n) + NW'(i_m) - NW'(1))
                                     : (NW'(w_rest) + NW'(w_avail) - NW'(1));
    assign w_bt    = i_cmd.tot_start ? i_n : w_rest;

    mu_binom #(.NW(NW)) u_binom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.tot_start | i_cmd.cnt_start),
        .i_n     (w_bn),
        .i_t     (w_bt),
        .o_done  (w_done),
        .o_count (w_count),
        .o_big   (w_big)
    );

    assign w_last_pos = (r_pos == i_n - LW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rank <= i_rank;
            r_base <= '0;
            r_left <= i_m;
            r_pos  <= '0;
            r_oor  <= 1'b0;
        end
        if (i_cmd.set_oor) begin
            r_oor <= !w_big && (r_rank >= w_count);
        end
        if (i_cmd.pos_init) begin
            r_off <= '0;
        end
        if (i_cmd.take) begin
            r_val  <= r_base + r_off;
            r_base <= r_base + r_off;
            r_left <= r_left - r_off;
        end
        if (i_cmd.sub) begin
            r_rank <= r_rank - w_count;
            r_off  <= r_off + VB'(1);
        end
        if (i_cmd.val_zero) begin
            r_val <= '0;
        end
        if (i_cmd.val_base) begin
            r_val <= r_base;
        end
        if (i_cmd.next_pos) begin
            r_pos <= r_pos + LW'(1);
        end
        if (i_cmd.emit) begin
            r_out_value <= r_val;
            r_out_last  <= w_last_pos;
            r_out_oor   <= r_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_sts.n_zero      = (i_n == '0);
    assign o_sts.binom_done  = w_done;
    assign o_sts.hit         = w_big || (w_count > r_rank);
    assign o_sts.off_lt_left = (r_off < r_left);
    assign o_sts.last_pos    = w_last_pos;
    assign o_sts.out_free    = !r_ov || i_out_ready;
    assign o_sts.oor         = r_oor;

    assign o_out_valid = r_ov;
    assign o_value     = r_out_value;
    assign o_last      = r_out_last;
    assign o_oor       = r_out_oor;

endmodule

@@ hdl/mu_ctrl.sv @@
// controller: walks positions and offsets, issues datapath commands
// depends on mu_pkg
`timescale 1ns / 1ps

module mu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mu_pkg::t_sts  i_sts,
    output mu_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOT  = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_TRY  = 3'd3;
    localparam logic [2:0] S_CNT  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_sts.n_zero) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.tot_start = 1'b1;
                    n_state         = S_TOT;
                end
            end
            S_TOT: begin
                if (i_sts.binom_done) begin
                    o_cmd.set_oor = 1'b1;
                    n_state       = S_POS;
                end
            end
            S_POS: begin
                if (i_sts.oor) begin
                    o_cmd.val_zero = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.pos_init = 1'b1;
                    n_state        = S_TRY;
                end
            end
            S_TRY: begin
                if (i_sts.off_lt_left) begin
                    o_cmd.cnt_start = 1'b1;
                    n_state         = S_CNT;
                end else begin
                    o_cmd.val_base = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_CNT: begin
                if (i_sts.binom_done) begin
                    if (i_sts.hit) begin
                        o_cmd.take = 1'b1;
                        n_state    = S_EMIT;
                    end else begin
                        o_cmd.sub = 1'b1;
                        n_state   = S_TRY;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_pos) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_pos = 1'b1;
                        n_state        = S_POS;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hdl/mu_checker.sv @@
// port-level checks on the unranker, bound to the top level
// depends on assert_macros.svh, multiset_unrank
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mu_checker #(
    parameter int VALUE_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [VALUE_BITS-1:0] out_value,
    input logic                  out_last,
    input logic                  out_oor
);

    // stalled result holds
    `MU_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last) && $stable(out_oor))

    // out-of-range results carry zero
    `MU_ASSERT_RST(a_oor_zero, clk, rst_n, out_valid && out_oor |-> out_value == '0)

    // no new rank while a sequence is part-way out
    `MU_ASSERT_RST(a_busy_mid_seq, clk, rst_n, out_valid && !out_last |-> !in_ready)

    // reset empties the result register
    `MU_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

endmodule

bind multiset_unrank mu_checker #(.VALUE_BITS(VALUE_BITS)) u_mu_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_ready  (i_rank_ch.ready),
    .out_valid (o_res_ch.valid),
    .out_ready (o_res_ch.ready),
    .out_value (o_res_ch.value),
    .out_last  (o_res_ch.last),
    .out_oor   (o_res_ch.out_of_range)
);

@@ tb/tb_multiset_unrank.sv @@
// self-checking testbench for the multiset combination unranker
// depends on mu_pkg, mu_rank_if, mu_res_if and multiset_unrank
`timescale 1ns / 1ps

module tb_multiset_unrank;

    localparam int  LEN_CAP    = 16;
    localparam int  VAL_W      = 16;
    localparam int  CYCLE_CAP  = 6000000;
    localparam int  SETTLE     = 60;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             oor;
    } t_seq_elem;

    // golden unranker plus the queue of sequence elements still owed by the block
    class unrank_scoreboard;
        int unsigned      len_reg;
        int unsigned      count_reg;
        t_seq_elem        owed[$];
        int               mismatches;

        function new();
            len_reg    = 1;
            count_reg  = 1;
            mismatches = 0;
        endfunction

        // exact binomial, top bit marks a value of 2^64 or more
        function logic [64:0] binomial(int unsigned n, int unsigned t);
            logic [127:0] acc;
            if (t > n) return 65'd0;
            if (t > n - t) t = n - t;
            acc = 128'd1;
            for (int unsigned i = 1; i <= t; i++) begin
                acc = (acc * (n - t + i)) / i;
                if (acc[127:64] != 0) return {1'b1, 64'd0};
            end
            return {1'b0, acc[63:0]};
        endfunction

        function int unsigned eff_len();
            return (len_reg > LEN_CAP) ? LEN_CAP : len_reg;
        endfunction

        function logic [64:0] total_count();
            if (eff_len() == 0) return 65'd0;
            return binomial(eff_len() + count_reg - 1, eff_len());
        endfunction

        // rank accepted: walk the sequence and queue every element
        function void note_rank(logic [63:0] rank);
            int unsigned n, left, base, val, rest;
            logic [64:0] tot, cnt;
            logic [63:0] rem;
            logic        oor;
            t_seq_elem   e;
            n = eff_len();
            if (n == 0) return;
            tot  = total_count();
            oor  = !tot[64] && (rank >= tot[63:0]);
            rem  = rank;
            base = 0;
            left = count_reg;
            for (int unsigned pos = 0; pos < n; pos++) begin
                val = 0;
                if (!oor) begin
                    rest = n - pos - 1;
                    val  = base;
                    for (int unsigned off = 0; off < left; off++) begin
                        cnt = binomial(rest + (left - off) - 1, rest);
                        if (cnt[64] || cnt[63:0] > rem) begin
                            val  = base + off;
                            base = val;
                            left = left - off;
                            break;
                        end
                        rem = rem - cnt[63:0];
                    end
                end
                e.value = val[VAL_W-1:0];
                e.last  = (pos == n - 1);
                e.oor   = oor;
                owed.push_back(e);
            end
        endfunction

        function void check(logic [VAL_W-1:0] value, logic last, logic oor);
            t_seq_elem e;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected element value=%0d last=%0b oor=%0b", value, last, oor);
                return;
            end
            e = owed.pop_front();
            if (e.value !== value || e.last !== last || e.oor !== oor) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("element mismatch: exp value=%0d last=%0b oor=%0b got %0d %0b %0b",
                             e.value, e.last, e.oor, value, last, oor);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mu_rank_if             rank_ch ();
    mu_res_if #(.VALUE_BITS(VAL_W)) res_ch ();

    multiset_unrank #(.MAX_LEN(LEN_CAP), .VALUE_BITS(VAL_W)) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rank_ch (rank_ch.sink),
        .o_res_ch  (res_ch.source),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    unrank_scoreboard sb = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 0;
    int unsigned hold_left      = 0;
    int unsigned cycles         = 0;

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL multiset_unrank");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request from the stimulus
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: sampled values at the edge are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check(res_ch.value, res_ch.last, res_ch.out_of_range);
    end

    // offer one rank, idle at random first, and note it once accepted
    task automatic send_rank(logic [63:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            rank_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rank_ch.valid <= 1'b1;
        rank_ch.rank  <= r;
        do @(posedge i_clk); while (!rank_ch.ready);
        sb.note_rank(r);
    endtask

    // wait until every owed element is back, then let the block settle
    task automatic drain();
        rank_ch.valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write: setup then access, block idle
    task automatic reg_write(logic idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == mu_pkg::REG_SEQ_LEN) sb.len_reg = data & 32'h1f;
        else                            sb.count_reg = data & 32'hffff;
    endtask

    task automatic set_shape(int unsigned len, int unsigned cnt);
        drain();
        reg_write(mu_pkg::REG_SEQ_LEN, len);
        reg_write(mu_pkg::REG_VALUE_COUNT, cnt);
    endtask

    // mostly in-range ranks, some at or just past the total, some fully random
    function automatic logic [63:0] pick_rank();
        logic [64:0] tot;
        logic [63:0] wide;
        int unsigned sel;
        tot  = sb.total_count();
        wide = {$urandom, $urandom};
        sel  = $urandom_range(99);
        if (sel < 15) return wide;
        if (sel < 30 && !tot[64]) return tot[63:0] + $urandom_range(2);
        if (tot[64]) return wide;
        if (tot[63:0] == 0) return wide;
        if (sel < 40) return tot[63:0] - 1;
        return wide % tot[63:0];
    endfunction

    initial begin
        logic [64:0] tot;
        int unsigned len, cnt;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rank_ch.valid = 1'b0;
        rank_ch.rank  = '0;
        res_ch.ready  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset shape, one value only
        send_rank(64'd0);
        send_rank(64'd1);
        send_rank('1);

        // zero length gives no elements at all
        set_shape(0, 5);
        send_rank(64'd0);
        send_rank('1);

        // longest sequence over the widest alphabet, counts saturate
        set_shape(16, 16'hffff);
        send_rank(64'd0);
        send_rank(64'd1);
        send_rank(64'd777);

        // single element over the widest alphabet: walks every offset
        set_shape(1, 16'hffff);
        send_rank(64'd65534);
        send_rank(64'd65535);

        // length above the cap is clipped to sixteen
        set_shape(31, 3);
        send_rank(64'd0);
        send_rank(64'd152);
        send_rank(64'd153);

        // full square, first and last rank, then one past the last
        set_shape(16, 16);
        tot = sb.total_count();
        send_rank(64'd0);
        send_rank(tot[63:0] - 1);
        send_rank(tot[63:0]);

        // empty alphabet: everything out of range
        set_shape(4, 0);
        send_rank(64'd0);
        send_rank(64'h8000_0000_0000_0000);

        // random part over four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int grp = 0; grp < 5; grp++) begin
                if ($urandom_range(9) == 0) len = $urandom_range(20);
                else                        len = $urandom_range(1, 16);
                if (len <= 3 && $urandom_range(3) == 0) cnt = $urandom_range(9, 40);
                else                                    cnt = $urandom_range(1, 8);
                set_shape(len, cnt);
                for (int k = 0; k < 5; k++) begin
                    // stall the output for a long stretch while ranks keep coming
                    if (ph == 0 && grp == 1 && k == 1) hold_req = 1;
                    // sender waits for the sequence stream to empty
                    if (ph == 3 && grp == 2 && k == 2) drain();
                    send_rank(pick_rank());
                end
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("PASS multiset_unrank");
        end else begin
            $display("FAIL multiset_unrank");
        end
        $finish;
    end

endmodule
